### rtl/cpp3d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Closest pair of points in 3-D: shared types and constants
// Field widths of the point and result beats, the point word kept in the
// store, and the step record passed down the square-root cell chain.
// ----------------------------------------------------------------------------
package cpp3d_pkg;

	// Fixed field widths.
	localparam int COORD_BITS = 22;
	localparam int SQ_BITS    = 45;
	localparam int ROOT_BITS  = 23;
	localparam int IDX_BITS   = 10;

	// Derived widths for the distance datapath and the root chain.
	localparam int SQR_BITS = 2 * COORD_BITS;
	localparam int SUM_BITS = SQR_BITS + 2;
	localparam int RAD_BITS = 2 * ROOT_BITS;
	localparam int REM_BITS = ROOT_BITS + 2;

	// One incoming point beat.
	typedef struct packed {
		logic [COORD_BITS-1:0] coord_x;
		logic [COORD_BITS-1:0] coord_y;
		logic [COORD_BITS-1:0] coord_z;
		logic                  last_point;
	} point_in_t;

	// One result beat.
	typedef struct packed {
		logic [SQ_BITS-1:0]   min_sq_distance;
		logic [ROOT_BITS-1:0] min_root;
		logic [IDX_BITS-1:0]  first_index;
		logic [IDX_BITS-1:0]  second_index;
		logic                 pair_found;
		logic                 overflow;
	} pair_out_t;

	// A point as held in the store.
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
	} point_t;

	// Partial state of the digit-by-digit square root.
	typedef struct packed {
		logic                 vld;
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
		logic [RAD_BITS-1:0]  rad;
	} root_step_t;

endpackage
`default_nettype wire

### rtl/cpp3d_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cpp3d_ram #(
	parameter int WIDTH     = 8,
	parameter int DEPTH     = 16,
	parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [ADDR_BITS-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]     wr_data,
	input  wire logic                 rd_en,
	input  wire logic [ADDR_BITS-1:0] rd_addr,
	output logic      [WIDTH-1:0]     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

### rtl/cpp3d_dist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Squared distance pipeline
// Three stages: absolute differences, squares, saturating sum. The index
// of the stored point travels with its data.
// ----------------------------------------------------------------------------
module cpp3d_dist
	import cpp3d_pkg::*;
#(
	parameter int IDX_W = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_vld,
	input  wire logic [IDX_W-1:0]   in_idx,
	input  wire point_t             a,
	input  wire point_t             b,
	output logic                    out_vld,
	output logic      [IDX_W-1:0]   out_idx,
	output logic      [SQ_BITS-1:0] out_sq,
	output logic                    busy
);

	logic                  vld_s1, vld_s2, vld_s3;
	logic [IDX_W-1:0]      idx_s1, idx_s2, idx_s3;
	logic [COORD_BITS-1:0] dx_s1, dy_s1, dz_s1;
	logic [SQR_BITS-1:0]   sx_s2, sy_s2, sz_s2;
	logic [SQ_BITS-1:0]    sq_s3;
	logic [SUM_BITS-1:0]   sum;

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: absolute coordinate differences.
	always_ff @(posedge clk) begin
		idx_s1 <= in_idx;
		dx_s1  <= (a.x >= b.x) ? (a.x - b.x) : (b.x - a.x);
		dy_s1  <= (a.y >= b.y) ? (a.y - b.y) : (b.y - a.y);
		dz_s1  <= (a.z >= b.z) ? (a.z - b.z) : (b.z - a.z);
	end

	// Stage 2: one multiplier per axis.
	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		sx_s2  <= SQR_BITS'(dx_s1) * SQR_BITS'(dx_s1);
		sy_s2  <= SQR_BITS'(dy_s1) * SQR_BITS'(dy_s1);
		sz_s2  <= SQR_BITS'(dz_s1) * SQR_BITS'(dz_s1);
	end

	// Stage 3: sum, clamped to the result width.
	assign sum = SUM_BITS'(sx_s2) + SUM_BITS'(sy_s2) + SUM_BITS'(sz_s2);

	always_ff @(posedge clk) begin
		idx_s3 <= idx_s2;
		sq_s3  <= (|sum[SUM_BITS-1:SQ_BITS]) ? '1 : sum[SQ_BITS-1:0];
	end

	assign out_vld = vld_s3;
	assign out_idx = idx_s3;
	assign out_sq  = sq_s3;
	assign busy    = vld_s1 | vld_s2 | vld_s3;

endmodule
`default_nettype wire

### rtl/cpp3d_root_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square-root cell
// Settles one bit of the root: brings down two radicand bits, tries the
// trial divisor and hands the updated partial state to the next cell.
// ----------------------------------------------------------------------------
module cpp3d_root_cell
	import cpp3d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire root_step_t step_in,
	output root_step_t      step_out
);

	logic [REM_BITS-1:0]  rem_sh;
	logic [REM_BITS-1:0]  trial;
	logic                 fits;
	root_step_t           nxt;
	logic                 vld_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [RAD_BITS-1:0]  rad_q;

	// Restoring step on the shifted remainder.
	always_comb begin
		rem_sh = {step_in.rem[REM_BITS-3:0], step_in.rad[RAD_BITS-1 -: 2]};
		trial  = {step_in.root, 2'b01};
		fits   = (rem_sh >= trial);
		nxt.vld  = step_in.vld;
		nxt.rem  = fits ? (rem_sh - trial) : rem_sh;
		nxt.root = {step_in.root[ROOT_BITS-2:0], fits};
		nxt.rad  = {step_in.rad[RAD_BITS-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= nxt.rem;
		root_q <= nxt.root;
		rad_q  <= nxt.rad;
	end

	assign step_out = '{vld: vld_q, rem: rem_q, root: root_q, rad: rad_q};

endmodule
`default_nettype wire

### rtl/cpp3d_root_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square-root cell chain
// A row of root cells, one per result bit, giving the floor square root
// of the squared distance; each cell registers its step.
// ----------------------------------------------------------------------------
module cpp3d_root_chain
	import cpp3d_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [SQ_BITS-1:0]   radicand,
	output logic                      done,
	output logic      [ROOT_BITS-1:0] root
);

	root_step_t link [ROOT_BITS+1];

	// Head of the chain: empty remainder and root, radicand zero-extended.
	assign link[0] = '{vld: start, rem: '0, root: '0, rad: RAD_BITS'(radicand)};

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_cell
		cpp3d_root_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.step_in  (link[k]),
			.step_out (link[k+1])
		);
	end

	assign done = link[ROOT_BITS].vld;
	assign root = link[ROOT_BITS].root;

endmodule
`default_nettype wire

### rtl/closest_pair_of_points_3d.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Closest pair of points in 3-D
// Points arrive one beat at a time on the point channel; a beat with
// last_point set closes the set and one result beat follows on the pair
// channel with the least squared distance, its floor square root and the
// index pair (earliest pair in (i, j) order on ties).
// Each accepted point is written to the point store and the points already
// held are read back one per cycle through the distance pipeline, the
// store's single read port setting that rate; the next beat is taken once
// the sweep has drained. The first point of a set, and a point that finds
// the store full (dropped and flagged), skip the sweep.
// A closing point then passes through the square-root cell chain and into
// the output register.
// point_stall is high while a point is being processed. The result sits
// in an output register; while pair_stall holds it, new points are still
// taken, and only a following closing point waits for the register.
// Reset empties the set; the store contents need no clearing.
// ----------------------------------------------------------------------------
module closest_pair_of_points_3d
	import cpp3d_pkg::*;
#(
	parameter int MAX_POINTS = 1024
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      point_valid,
	output logic           point_stall,
	input  wire point_in_t point,
	output logic           pair_valid,
	input  wire logic      pair_stall,
	output pair_out_t      pair
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SWEEP = 6'b000010,
		S_DRAIN = 6'b000100,
		S_CLOSE = 6'b001000,
		S_ROOT  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        loaded_q;
	logic [AW-1:0]        j_q;
	logic [AW-1:0]        rd_idx_q;
	logic                 last_q;
	logic                 have_q;
	logic                 dropped_q;
	logic [SQ_BITS-1:0]   best_sq_q;
	logic [AW-1:0]        best_first_q;
	logic [AW-1:0]        best_second_q;
	point_t               p_q;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_idx_s1;

	logic [SQ_BITS-1:0]   pend_sq_q;
	logic [AW-1:0]        pend_first_q;
	logic [AW-1:0]        pend_second_q;
	logic                 pend_found_q;
	logic                 pend_ovf_q;
	logic [ROOT_BITS-1:0] pend_root_q;

	logic                 out_valid_q;
	pair_out_t            out_q;

	logic                 accept;
	logic                 room;
	logic                 found;
	logic                 wr_en;
	logic                 rd_en;
	point_t               p_in;
	logic [$bits(point_t)-1:0] rd_word;
	logic                 d_vld;
	logic [AW-1:0]        d_idx;
	logic [SQ_BITS-1:0]   d_sq;
	logic                 d_busy;
	logic                 take;
	logic                 root_start;
	logic                 root_done;
	logic [ROOT_BITS-1:0] root;
	logic                 out_free;

	// Handshake and store access.
	assign point_stall = (state_q != S_IDLE);
	assign accept      = point_valid && !point_stall;
	assign room        = (loaded_q < CW'(MAX_POINTS));
	assign found       = (loaded_q >= CW'(2));
	assign wr_en       = accept && room;
	assign rd_en       = (state_q == S_SWEEP);
	assign p_in        = '{x: point.coord_x, y: point.coord_y, z: point.coord_z};
	assign root_start  = (state_q == S_CLOSE) && last_q;
	assign out_free    = !out_valid_q || !pair_stall;

	cpp3d_ram #(
		.WIDTH     ($bits(point_t)),
		.DEPTH     (MAX_POINTS),
		.ADDR_BITS (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (loaded_q[AW-1:0]),
		.wr_data (p_in),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_word)
	);

	cpp3d_dist #(
		.IDX_W (AW)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (rd_vld_s1),
		.in_idx  (rd_idx_s1),
		.a       (point_t'(rd_word)),
		.b       (p_q),
		.out_vld (d_vld),
		.out_idx (d_idx),
		.out_sq  (d_sq),
		.busy    (d_busy)
	);

	cpp3d_root_chain u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (found ? best_sq_q : '0),
		.done     (root_done),
		.root     (root)
	);

	// A new pair wins on a smaller distance, or on a tie with an earlier first point.
	assign take = d_vld && (!have_q || (d_sq < best_sq_q) ||
		((d_sq == best_sq_q) && (d_idx < best_first_q)));

	// Read side of the sweep: the valid and index are registered alongside the RAM read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q;
	end

	// Point register for the sweep.
	always_ff @(posedge clk) begin
		if (accept) begin
			p_q <= p_in;
		end
	end

	// Sequencer, set state and running minimum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			loaded_q      <= '0;
			j_q           <= '0;
			rd_idx_q      <= '0;
			last_q        <= 1'b0;
			have_q        <= 1'b0;
			dropped_q     <= 1'b0;
			best_sq_q     <= '1;
			best_first_q  <= '0;
			best_second_q <= '0;
		end else begin
			if (take) begin
				best_sq_q     <= d_sq;
				best_first_q  <= d_idx;
				best_second_q <= j_q;
				have_q        <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q   <= point.last_point;
						rd_idx_q <= '0;
						j_q      <= loaded_q[AW-1:0];
						have_q   <= found;
						if (!room) begin
							dropped_q <= 1'b1;
							state_q   <= S_CLOSE;
						end else begin
							loaded_q <= loaded_q + CW'(1);
							state_q  <= (loaded_q == '0) ? S_CLOSE : S_SWEEP;
						end
					end
				end
				S_SWEEP: begin
					rd_idx_q <= rd_idx_q + AW'(1);
					if (rd_idx_q == j_q - AW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rd_vld_s1 && !d_busy) begin
						state_q <= S_CLOSE;
					end
				end
				S_CLOSE: begin
					if (last_q) begin
						loaded_q      <= '0;
						dropped_q     <= 1'b0;
						have_q        <= 1'b0;
						best_sq_q     <= '1;
						best_first_q  <= '0;
						best_second_q <= '0;
						state_q       <= S_ROOT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_ROOT: begin
					if (root_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result fields held while the root chain runs.
	always_ff @(posedge clk) begin
		if (root_start) begin
			pend_sq_q     <= found ? best_sq_q : '0;
			pend_first_q  <= found ? best_first_q : '0;
			pend_second_q <= found ? best_second_q : '0;
			pend_found_q  <= found;
			pend_ovf_q    <= dropped_q;
		end
		if ((state_q == S_ROOT) && root_done) begin
			pend_root_q <= root;
		end
	end

	// Output register: loaded from the pending result, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!pair_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && out_free) begin
			out_q.min_sq_distance <= pend_sq_q;
			out_q.min_root        <= pend_root_q;
			out_q.first_index     <= IDX_BITS'(pend_first_q);
			out_q.second_index    <= IDX_BITS'(pend_second_q);
			out_q.pair_found      <= pend_found_q;
			out_q.overflow        <= pend_ovf_q;
		end
	end

	assign pair_valid = out_valid_q;
	assign pair       = out_q;

endmodule
`default_nettype wire
